// ----- sv/bitmap_slot_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// Slot allocator assertion macros
// Shared concurrent assertion forms for the allocator modules.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BSA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// Slot allocator package
// Types, codes and helper functions shared by the allocator modules.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int WORD_BITS  = 64;
   localparam int MAX_SLOTS  = 256;
   localparam int MAX_WORDS  = MAX_SLOTS / WORD_BITS;
   localparam int SLOT_W     = 8;
   localparam int BIT_W      = 6;
   localparam int WSEL_W     = SLOT_W - BIT_W;
   localparam int ACTIVE_W   = 9;
   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SCAN    = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REL_ERR = 2'd2;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 9'd256;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] pos;
   } ffs_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture the request beat
      logic step;     // evaluate the current word
      logic advance;  // move to the next word
      logic write;    // write back the updated word
      logic finish;   // load the response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic hit;
      logic need_write;
      logic stop;
      logic rsp_free;
   } stat_type;

   // lowest set bit of a word
   function automatic ffs_type find_first(input word_type v);
      ffs_type r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r.found = 1'b1;
            r.pos   = BIT_W'(i);
         end
      end
      return r;
   endfunction

endpackage

// ----- sv/bitmap_slot_allocator.sv -----
// A request beat is captured in idle, the walk then steps through bitmap words, a write-back
//   state follows when a word is updated (allocate, good release), and the result is loaded
//   into the response register once it is free; only then is a new request taken. Allocate and
//   scan walk one 64-bit bitmap word per cycle, each through its own find-first unit.
// Reset (synchronous, active high) frees every slot, sets active_slots to 256 and
//   drops any pending response.
// ----------------------------------------------------------------------------
// Bitmap slot allocator
// Allocates, releases and scans slots held in a bitmap of 64-bit words.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator #(
   parameter int NUM_WORDS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [bsa_pkg::REQ_DATA_W-1:0]       req_tdata,  // slot_index, own_slot, skip_own
   input  logic [bsa_pkg::FUNC_W-1:0]           req_tuser,  // func
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bsa_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // result_slot, status, all_free
   // active_slots register
   input  logic                                 csr_we,
   input  logic [bsa_pkg::ACTIVE_W-1:0]         csr_wdata
);
   import bsa_pkg::*;

   // The controller steps through capture, word walk, write-back and response;
   // the datapath holds the bitmap, its per-word summaries and the response
   // register, so a finished beat can wait on the response side while the
   // controller is already back in idle and taking the next request.
   cmd_type  cmd;
   stat_type stat;

   bsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Walk one word per step; emptiness comes from per-word nonzero and
   // single-bit summaries refreshed on every write-back.
   bsa_datapath #(
      .NUM_WORDS (NUM_WORDS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- sv/bsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Slot allocator controller
// Sequences request capture, word walk, write-back and response.
// ----------------------------------------------------------------------------
`include "bitmap_slot_allocator_macros.svh"

module bsa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  bsa_pkg::stat_type stat,
   output bsa_pkg::cmd_type  cmd
);
   import bsa_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // take no beat while reset is held
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (stat.need_write) begin
               state_in = ST_WRITE;
            end else if (stat.hit || stat.stop) begin
               state_in = ST_DONE;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            // hold until the response register can take the result
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `BSA_ASSERT_NEXT(a_accept_walks, clock, reset, req_tvalid && req_tready, state_ff == ST_WALK, "accepted beat did not start a walk")
   `BSA_ASSERT_NEXT(a_write_done, clock, reset, state_ff == ST_WRITE, state_ff == ST_DONE, "write-back not followed by response")
   `BSA_ASSERT_SAME(a_ready_idle, clock, reset, req_tready, state_ff == ST_IDLE, "request ready outside idle")

endmodule

// ----- sv/bsa_datapath.sv -----
// ----------------------------------------------------------------------------
// Slot allocator datapath
// Bitmap words, per-word summaries, word walk logic and response register.
// ----------------------------------------------------------------------------
`include "bitmap_slot_allocator_macros.svh"

module bsa_datapath #(
   parameter int NUM_WORDS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bsa_pkg::cmd_type                     cmd,
   output bsa_pkg::stat_type                    stat,
   input  logic [bsa_pkg::FUNC_W-1:0]           req_tuser,
   input  logic [bsa_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                 csr_we,
   input  logic [bsa_pkg::ACTIVE_W-1:0]         csr_wdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bsa_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import bsa_pkg::*;

   // only words below slot 256 can ever hold a slot
   localparam int LIVE_WORDS = (NUM_WORDS < MAX_WORDS) ? NUM_WORDS : MAX_WORDS;
   localparam int WPTR_W     = (LIVE_WORDS > 1) ? $clog2(LIVE_WORDS) : 1;
   localparam logic [WSEL_W:0] LIVE_LIM = (WSEL_W + 1)'(LIVE_WORDS);

   // storage and per-word summaries
   word_type               bitmap_ff [LIVE_WORDS];
   logic [LIVE_WORDS-1:0]  nz_ff;
   logic [LIVE_WORDS-1:0]  single_ff;
   logic [BIT_W-1:0]       lowpos_ff [LIVE_WORDS];
   logic [ACTIVE_W-1:0]    active_ff;

   // captured request
   logic [FUNC_W-1:0]      func_ff;
   logic [SLOT_W-1:0]      idx_ff;
   logic [SLOT_W-1:0]      own_ff;
   logic                   skip_ff;
   logic                   first_ff;
   logic [WSEL_W-1:0]      ptr_ff;
   logic [WSEL_W-1:0]      ptr_in;

   // step results
   word_type               wdata_ff;
   word_type               wdata_in;
   logic [SLOT_W-1:0]      slot_ff;
   logic [SLOT_W-1:0]      slot_in;
   logic [STATUS_W-1:0]    status_ff;
   logic [STATUS_W-1:0]    status_in;

   // response register
   logic                   rsp_valid_ff;
   logic [SLOT_W-1:0]      rsp_slot_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic                   rsp_empty_ff;

   logic                   in_range;
   word_type               word_rd;
   word_type               scan_mask;
   ffs_type                free_hit;
   ffs_type                held_hit;
   ffs_type                wr_first;
   logic [WSEL_W:0]        ptr_next;
   logic                   scan_end;
   logic                   rel_ok;
   logic                   empty_now;
   logic                   sum_ok;
   word_type               wr_dec;

   assign in_range = ({1'b0, ptr_ff} < LIVE_LIM);
   assign word_rd  = in_range ? bitmap_ff[ptr_ff[WPTR_W-1:0]] : '0;
   assign ptr_next = {1'b0, ptr_ff} + (WSEL_W + 1)'(1);

   always_comb begin
      scan_mask = word_rd & ({WORD_BITS{1'b1}} << (first_ff ? idx_ff[BIT_W-1:0] : '0));
      if (skip_ff && own_ff[SLOT_W-1:BIT_W] == ptr_ff) begin
         scan_mask[own_ff[BIT_W-1:0]] = 1'b0;
      end
   end

   assign free_hit = find_first(~word_rd);
   assign held_hit = find_first(scan_mask);
   assign rel_ok   = in_range && word_rd[idx_ff[BIT_W-1:0]];
   // give up after the word holding the last active slot, or the last word
   assign scan_end = ({ptr_next, {BIT_W{1'b0}}} >= active_ff) || (ptr_next >= LIVE_LIM);

   always_comb begin
      stat      = '0;
      wdata_in  = wdata_ff;
      slot_in   = '0;
      status_in = STATUS_OK;
      case (func_ff)
         FUNC_ALLOC: begin
            stat.hit        = in_range && free_hit.found;
            stat.need_write = stat.hit;
            stat.stop       = !stat.hit && (ptr_next >= LIVE_LIM);
            wdata_in        = word_rd | (word_type'(1) << free_hit.pos);
            slot_in         = stat.hit ? {ptr_ff, free_hit.pos} : '0;
            status_in       = stat.hit ? STATUS_OK : STATUS_NONE;
         end
         FUNC_RELEASE: begin
            stat.need_write = rel_ok;
            stat.stop       = !rel_ok;
            wdata_in        = word_rd & ~(word_type'(1) << idx_ff[BIT_W-1:0]);
            status_in       = rel_ok ? STATUS_OK : STATUS_REL_ERR;
         end
         FUNC_SCAN: begin
            stat.hit  = in_range && held_hit.found;
            stat.stop = !stat.hit && (!in_range || scan_end);
            slot_in   = stat.hit ? {ptr_ff, held_hit.pos} : '0;
            status_in = stat.hit ? STATUS_OK : STATUS_NONE;
         end
         default: begin
            stat.stop = 1'b1;
         end
      endcase
      stat.rsp_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.load) begin
         ptr_in = (req_tuser == FUNC_ALLOC) ? '0 : req_tdata[SLOT_W-1:BIT_W];
      end else if (cmd.advance) begin
         ptr_in = ptr_next[WSEL_W-1:0];
      end
   end

   // emptiness from the summaries; a word holding only own slot is skipped
   always_comb begin
      empty_now = 1'b1;
      for (int w = 0; w < LIVE_WORDS; w++) begin
         if (nz_ff[w] && !(skip_ff && own_ff[SLOT_W-1:BIT_W] == WSEL_W'(w) &&
                           single_ff[w] && lowpos_ff[w] == own_ff[BIT_W-1:0])) begin
            empty_now = 1'b0;
         end
      end
   end

   assign wr_dec   = wdata_ff & (wdata_ff - word_type'(1));
   assign wr_first = find_first(wdata_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < LIVE_WORDS; w++) begin
            bitmap_ff[w] <= '0;
         end
         nz_ff     <= '0;
         single_ff <= '0;
         active_ff <= ACTIVE_RESET;
      end else begin
         if (csr_we) begin
            active_ff <= csr_wdata;
         end
         if (cmd.write) begin
            bitmap_ff[ptr_ff[WPTR_W-1:0]] <= wdata_ff;
            nz_ff[ptr_ff[WPTR_W-1:0]]     <= |wdata_ff;
            single_ff[ptr_ff[WPTR_W-1:0]] <= (wr_dec == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         lowpos_ff[ptr_ff[WPTR_W-1:0]] <= wr_first.pos;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_tuser;
         idx_ff  <= req_tdata[SLOT_W-1:0];
         own_ff  <= req_tdata[2*SLOT_W-1:SLOT_W];
         skip_ff <= req_tdata[2*SLOT_W];
      end
      ptr_ff <= ptr_in;
      if (cmd.load || cmd.advance) begin
         first_ff <= cmd.load;
      end
      if (cmd.step) begin
         wdata_ff  <= wdata_in;
         slot_ff   <= slot_in;
         status_ff <= status_in;
      end
      if (cmd.finish) begin
         rsp_slot_ff   <= slot_ff;
         rsp_status_ff <= status_ff;
         rsp_empty_ff  <= empty_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - SLOT_W - STATUS_W - 1){1'b0}},
                        rsp_empty_ff, rsp_status_ff, rsp_slot_ff};

   always_comb begin
      sum_ok = 1'b1;
      for (int w = 0; w < LIVE_WORDS; w++) begin
         if (nz_ff[w] != (|bitmap_ff[w])) begin
            sum_ok = 1'b0;
         end
      end
   end

   `BSA_ASSERT_SAME(a_summary, clock, reset, 1'b1, sum_ok, "word summary out of step with bitmap")
   `BSA_ASSERT_SAME(a_finish_free, clock, reset, cmd.finish, !rsp_valid_ff || rsp_tready, "response overwritten while pending")
   `BSA_ASSERT_SAME(a_status_code, clock, reset, rsp_valid_ff, rsp_status_ff != 2'd3, "undefined status code on response")

endmodule

// ----- sim/tb_bitmap_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// Bitmap slot allocator testbench
// Runs allocate, release and scan requests through the allocator under random
// stalls on both streams. A scoreboard keeps its own copy of the slot bitmap
// and the active_slots register, works out each response, and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb_bitmap_slot_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   import bsa_pkg::*;

   localparam int NUM_WORDS = 4;
   // slots that exist: the bitmap size, capped by the 8-bit slot field
   localparam int SLOT_CAP  = (NUM_WORDS * WORD_BITS > MAX_SLOTS) ?
                              MAX_SLOTS : NUM_WORDS * WORD_BITS;

   // the fourth func code has no operation behind it
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [SLOT_W-1:0] slot_index;
      logic [SLOT_W-1:0] own_slot;
      logic              skip_own;
   } slot_req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   result_slot;
      logic [STATUS_W-1:0] status;
      logic                all_free;
   } slot_rsp_type;

   // one row of the directed table; fixed rows carry a response typed in here
   typedef struct packed {
      slot_req_type q;
      logic         fixed;
      slot_rsp_type r;
   } dir_row_type;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_type;

   localparam slot_rsp_type PREDICTED = '0;

   localparam int NUM_DIRECTED = 22;
   localparam dir_row_type DIRECTED [NUM_DIRECTED] = '{
      // empty bitmap: scan finds nothing, release of a free slot is an error
      '{'{FUNC_SCAN,    8'd0,   8'd0,   1'b0}, 1'b1, '{8'd0, STATUS_NONE,    1'b1}},
      '{'{FUNC_RELEASE, 8'd0,   8'd0,   1'b0}, 1'b1, '{8'd0, STATUS_REL_ERR, 1'b1}},
      '{'{FUNC_UNUSED,  8'd0,   8'd0,   1'b0}, 1'b1, '{8'd0, STATUS_OK,      1'b1}},
      '{'{FUNC_ALLOC,   8'd0,   8'd0,   1'b0}, 1'b1, '{8'd0, STATUS_OK,      1'b0}},
      // only the caller's own slot is held: skipped by scan and empty check
      '{'{FUNC_SCAN,    8'd0,   8'd0,   1'b1}, 1'b1, '{8'd0, STATUS_NONE,    1'b1}},
      '{'{FUNC_SCAN,    8'd0,   8'd0,   1'b0}, 1'b1, '{8'd0, STATUS_OK,      1'b0}},
      '{'{FUNC_RELEASE, 8'd0,   8'd0,   1'b0}, 1'b1, '{8'd0, STATUS_OK,      1'b1}},
      '{'{FUNC_RELEASE, 8'd255, 8'd255, 1'b1}, 1'b1, '{8'd0, STATUS_REL_ERR, 1'b1}},
      '{'{FUNC_ALLOC,   8'd255, 8'd255, 1'b1}, 1'b1, '{8'd0, STATUS_OK,      1'b0}},
      '{'{FUNC_ALLOC,   8'd0,   8'd0,   1'b0}, 1'b1, '{8'd1, STATUS_OK,      1'b0}},
      '{'{FUNC_ALLOC,   8'd0,   8'd0,   1'b0}, 1'b1, '{8'd2, STATUS_OK,      1'b0}},
      '{'{FUNC_SCAN,    8'd1,   8'd1,   1'b1}, 1'b0, PREDICTED},
      '{'{FUNC_SCAN,    8'd255, 8'd0,   1'b0}, 1'b0, PREDICTED},
      '{'{FUNC_RELEASE, 8'd1,   8'd0,   1'b0}, 1'b0, PREDICTED},
      '{'{FUNC_RELEASE, 8'd2,   8'd0,   1'b1}, 1'b0, PREDICTED},
      '{'{FUNC_UNUSED,  8'd255, 8'd255, 1'b1}, 1'b0, PREDICTED},
      '{'{FUNC_SCAN,    8'd64,  8'd0,   1'b0}, 1'b0, PREDICTED},
      '{'{FUNC_SCAN,    8'd63,  8'd0,   1'b1}, 1'b0, PREDICTED},
      '{'{FUNC_ALLOC,   8'd170, 8'd85,  1'b0}, 1'b0, PREDICTED},
      '{'{FUNC_RELEASE, 8'd170, 8'd85,  1'b1}, 1'b0, PREDICTED},
      '{'{FUNC_SCAN,    8'd85,  8'd170, 1'b1}, 1'b0, PREDICTED},
      '{'{FUNC_SCAN,    8'd0,   8'd1,   1'b1}, 1'b0, PREDICTED}
   };

   // random phases: item count, op mix and active_slots setting
   localparam int         NUM_PHASES = 5;
   localparam int         PHASE_ITEMS  [NUM_PHASES] = '{330, 300, 330, 210, 180};
   localparam op_mix_type PHASE_MIX    [NUM_PHASES] =
      '{MIX_FILL, MIX_DRAIN, MIX_FILL, MIX_DRAIN, MIX_EVEN};
   localparam int         PHASE_ACTIVE [NUM_PHASES] = '{1, 255, 64, 256, 0};

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;  // slot_index, own_slot, skip_own
   logic [FUNC_W-1:0]       req_tuser  = '0;  // func
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;        // result_slot, status, all_free
   logic                    csr_we     = 1'b0;
   logic [ACTIVE_W-1:0]     csr_wdata  = '0;

   // scoreboard copy of the block state
   word_type            slot_words [NUM_WORDS];
   logic [ACTIVE_W-1:0] active_limit = ACTIVE_RESET;

   slot_rsp_type slot_results_due [$];
   int           failures  = 0;
   logic         req_burst = 1'b0;
   logic         rsp_burst = 1'b0;

   bitmap_slot_allocator #(
      .NUM_WORDS(NUM_WORDS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      for (int w = 0; w < NUM_WORDS; w++) slot_words[w] = '0;
   end

   // Apply one request to the scoreboard bitmap and return its response.
   function automatic slot_rsp_type predict_slot_op(input slot_req_type q);
      slot_rsp_type p;
      logic         hit;
      logic         stop;
      int           s;
      int           w;
      int           b;
      p   = '0;
      hit = 1'b0;
      case (q.func)
         FUNC_ALLOC: begin
            p.status = STATUS_NONE;
            for (s = 0; s < SLOT_CAP && !hit; s++) begin
               if (!slot_words[s / WORD_BITS][s % WORD_BITS]) begin
                  slot_words[s / WORD_BITS][s % WORD_BITS] = 1'b1;
                  p.result_slot = SLOT_W'(s);
                  p.status      = STATUS_OK;
                  hit           = 1'b1;
               end
            end
         end
         FUNC_RELEASE: begin
            s = int'(q.slot_index);
            if (s < SLOT_CAP && slot_words[s / WORD_BITS][s % WORD_BITS]) begin
               slot_words[s / WORD_BITS][s % WORD_BITS] = 1'b0;
               p.status = STATUS_OK;
            end else begin
               p.status = STATUS_REL_ERR;
            end
         end
         FUNC_SCAN: begin
            // start word from the start bit, then whole words while in reach
            p.status = STATUS_NONE;
            w    = int'(q.slot_index) / WORD_BITS;
            b    = int'(q.slot_index) % WORD_BITS;
            stop = 1'b0;
            while (!stop && w < NUM_WORDS) begin
               for (; b < WORD_BITS && !hit; b++) begin
                  s = w * WORD_BITS + b;
                  if (slot_words[w][b] && !(q.skip_own && s == int'(q.own_slot))) begin
                     p.result_slot = SLOT_W'(s);
                     p.status      = STATUS_OK;
                     hit           = 1'b1;
                  end
               end
               if (hit || (w + 1) * WORD_BITS >= int'(active_limit)) begin
                  stop = 1'b1;
               end else begin
                  w = w + 1;
                  b = 0;
               end
            end
         end
         default: begin
         end
      endcase
      // empty check; with skip_own a word holding only the own bit is ignored
      p.all_free = 1'b1;
      for (w = 0; w < NUM_WORDS; w++) begin
         if (slot_words[w] != '0 &&
             !(q.skip_own && w == int'(q.own_slot) / WORD_BITS &&
               slot_words[w] == (word_type'(1) << q.own_slot[BIT_W-1:0]))) begin
            p.all_free = 1'b0;
         end
      end
      return p;
   endfunction

   // Pick a held slot at random, or -1 when the bitmap is empty.
   function automatic int pick_held_slot();
      int start;
      int s;
      start = $urandom_range(0, SLOT_CAP - 1);
      for (int i = 0; i < SLOT_CAP; i++) begin
         s = (start + i) % SLOT_CAP;
         if (slot_words[s / WORD_BITS][s % WORD_BITS]) return s;
      end
      return -1;
   endfunction

   // Draw a random request; the mix steers the bitmap toward full or empty.
   function automatic slot_req_type draw_request(input op_mix_type mix);
      slot_req_type q;
      int           r;
      int           held;
      int           alloc_cut;
      int           release_cut;
      q.slot_index = SLOT_W'($urandom_range(0, 255));
      q.own_slot   = SLOT_W'($urandom_range(0, 255));
      q.skip_own   = 1'($urandom_range(0, 1));
      case (mix)
         MIX_FILL:  begin alloc_cut = 70; release_cut = 82; end
         MIX_DRAIN: begin alloc_cut = 12; release_cut = 72; end
         default:   begin alloc_cut = 35; release_cut = 65; end
      endcase
      r = $urandom_range(0, 99);
      if (r < alloc_cut) begin
         q.func = FUNC_ALLOC;
      end else if (r < release_cut) begin
         q.func = FUNC_RELEASE;
         held   = pick_held_slot();
         // mostly release held slots, now and then a free one
         if (held >= 0 && $urandom_range(0, 99) < 85) q.slot_index = SLOT_W'(held);
      end else if (r < 96) begin
         q.func = FUNC_SCAN;
         held   = pick_held_slot();
         // aim own_slot at held slots and the start so skipping matters
         r = $urandom_range(0, 3);
         if (r < 2 && held >= 0) q.own_slot = SLOT_W'(held);
         else if (r == 2)        q.own_slot = q.slot_index;
      end else begin
         q.func = FUNC_UNUSED;
      end
      return q;
   endfunction

   // Drive one request beat after a random gap; log its response once taken.
   task automatic send_slot_request(input slot_req_type q, input logic fixed,
                                    input slot_rsp_type fixed_rsp);
      int           gap;
      slot_rsp_type pred;
      if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= q.func;
      req_tdata  <= {{(REQ_DATA_W - 2 * SLOT_W - 1){1'b0}},
                     q.skip_own, q.own_slot, q.slot_index};
      do @(posedge clock); while (!req_tready);
      pred = predict_slot_op(q);
      slot_results_due.push_back(fixed ? fixed_rsp : pred);
   endtask

   // Hold the request stream until every response is back, then write the register.
   task automatic write_active_slots(input logic [ACTIVE_W-1:0] value);
      req_tvalid <= 1'b0;
      while (slot_results_due.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_we       <= 1'b1;
      csr_wdata    <= value;
      active_limit  = value;
      @(posedge clock);
      csr_we <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         failures++;
         $display("%0t ns: %s expected %0d actual %0d", $realtime, name, want, got);
      end
   endtask

   // Response side: random stalls on tready, compare each beat with the oldest entry.
   initial begin
      slot_rsp_type want;
      slot_rsp_type got;
      int           stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.result_slot = rsp_tdata[SLOT_W-1:0];
            got.status      = rsp_tdata[SLOT_W +: STATUS_W];
            got.all_free    = rsp_tdata[SLOT_W + STATUS_W];
            if (slot_results_due.size() == 0) begin
               failures++;
               $display("%0t ns: response beat with none expected, actual %h",
                        $realtime, rsp_tdata);
            end else begin
               want = slot_results_due.pop_front();
               check_field("result_slot", want.result_slot, got.result_slot);
               check_field("status",      want.status,      got.status);
               check_field("all_free",    want.all_free,    got.all_free);
            end
            if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
            stall_left = rsp_burst ? 0 : $urandom_range(0, 7);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_tready <= !reset && stall_left == 0;
      end
   end

   // Stimulus: directed table first, then phases of random requests.
   initial begin
      int active_value;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_slot_request(DIRECTED[i].q, DIRECTED[i].fixed, DIRECTED[i].r);
      end
      for (int p = 0; p < NUM_PHASES; p++) begin
         active_value = (PHASE_ACTIVE[p] == 0) ? $urandom_range(1, MAX_SLOTS) :
                                                 PHASE_ACTIVE[p];
         write_active_slots(ACTIVE_W'(active_value));
         for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
            send_slot_request(draw_request(PHASE_MIX[p]), 1'b0, PREDICTED);
         end
      end
      req_tvalid <= 1'b0;
      while (slot_results_due.size() != 0) @(posedge clock);
      // drain: let any stray beat show up
      repeat (16) @(posedge clock);
      if (failures == 0) begin
         $display("bitmap_slot_allocator: match");
      end else begin
         $display("bitmap_slot_allocator: mismatch");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2ms;
      $display("bitmap_slot_allocator: mismatch");
      $finish;
   end

endmodule
